FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/arf_pkg.sv
package arf_pkg;

    // frame layout
    localparam int MIN_FRAME = 42;
    localparam logic [5:0] MIN_FRAME_COUNT = 6'(MIN_FRAME);
    localparam logic [5:0] POS_SRC_FIRST = 6'd6;
    localparam logic [5:0] POS_SRC_LAST = 6'd11;
    localparam logic [5:0] POS_ETYPE_FIRST = 6'd12;
    localparam logic [5:0] POS_ETYPE_LAST = 6'd13;
    localparam logic [5:0] POS_HW_FIRST = 6'd14;
    localparam logic [5:0] POS_HW_LAST = 6'd15;
    localparam logic [5:0] POS_PROTO_FIRST = 6'd16;
    localparam logic [5:0] POS_PROTO_LAST = 6'd17;
    localparam logic [5:0] POS_HLEN = 6'd18;
    localparam logic [5:0] POS_PLEN = 6'd19;
    localparam logic [5:0] POS_OP_FIRST = 6'd20;
    localparam logic [5:0] POS_OP_LAST = 6'd21;
    localparam logic [5:0] POS_SHA_FIRST = 6'd22;
    localparam logic [5:0] POS_SHA_LAST = 6'd27;
    localparam logic [5:0] POS_SPA_FIRST = 6'd28;
    localparam logic [5:0] POS_SPA_LAST = 6'd31;
    localparam logic [5:0] POS_THA_FIRST = 6'd32;
    localparam logic [5:0] POS_THA_LAST = 6'd37;
    localparam logic [5:0] POS_TPA_FIRST = 6'd38;
    localparam logic [5:0] POS_TPA_LAST = 6'd41;

    // protocol constants
    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] HW_ETHER = 16'h0001;
    localparam logic [7:0] HLEN_ETHER = 8'd6;
    localparam logic [7:0] PLEN_IPV4 = 8'd4;

    // opcodes
    localparam logic [15:0] OP_ARP_REQUEST = 16'd1;
    localparam logic [15:0] OP_ARP_REPLY = 16'd2;
    localparam logic [15:0] OP_RARP_REQUEST = 16'd3;
    localparam logic [15:0] OP_RARP_REPLY = 16'd4;

    // awaited answer modes
    localparam logic [2:0] MODE_ARP_REPLY = 3'd1;
    localparam logic [2:0] MODE_ARP_REQUEST = 3'd2;
    localparam logic [2:0] MODE_RARP_REPLY = 3'd3;
    localparam logic [2:0] MODE_RARP_REQUEST = 3'd4;

    // mismatch flag bits
    localparam int FLAG_ETYPE = 0;
    localparam int FLAG_SRC = 1;
    localparam int FLAG_TPA = 2;
    localparam int FLAG_THA = 3;
    localparam int FLAG_HW = 4;
    localparam int FLAG_PROTO = 5;
    localparam int FLAG_LEN = 6;
    localparam int FLAG_W = 7;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_SRC_FILTER_ENABLE = 3'd1;
    localparam logic [2:0] CFG_SRC_FILTER_MAC = 3'd2;
    localparam logic [2:0] CFG_KEEP_BROADCAST = 3'd3;
    localparam logic [2:0] CFG_OWN_IP = 3'd4;
    localparam logic [2:0] CFG_OWN_MAC = 3'd5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic [2:0] {
        REASON_OK = 3'd0,
        REASON_SHORT = 3'd1,
        REASON_NOT_ARP = 3'd2,
        REASON_SOURCE = 3'd3,
        REASON_OPCODE = 3'd4,
        REASON_LAST_MAC = 3'd5,
        REASON_TARGET = 3'd6,
        REASON_FORMAT = 3'd7
    } reason_t;

    typedef struct packed {
        logic       func;
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  reject_reason;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        src_filter_enable;
        logic [47:0] src_filter_mac;
        logic        keep_broadcast;
        logic [31:0] own_ip;
        logic [47:0] own_mac;
    } cfg_t;

    // register values after reset
    localparam cfg_t CFG_RESET = '{
        mode: MODE_ARP_REPLY,
        src_filter_enable: 1'b0,
        src_filter_mac: 48'd0,
        keep_broadcast: 1'b0,
        own_ip: 32'd0,
        own_mac: 48'd0
    };

    // one queued record: a finished frame or a forget event
    typedef struct packed {
        logic              is_forget;
        logic              short_frame;
        logic [FLAG_W-1:0] flags;
        logic [15:0]       opcode;
        logic [47:0]       sender_mac;
        logic [31:0]       sender_ip;
        logic [2:0]        mode;
        logic              src_filter_enable;
        logic              keep_broadcast;
    } rec_t;

    // byte k of a mac, k = 0 is the first byte on the wire
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0: b = mac[47:40];
            3'd1: b = mac[39:32];
            3'd2: b = mac[31:24];
            3'd3: b = mac[23:16];
            3'd4: b = mac[15:8];
            3'd5: b = mac[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // byte k of an ipv4 address, k = 0 is the first byte on the wire
    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0: b = ip[31:24];
            2'd1: b = ip[23:16];
            2'd2: b = ip[15:8];
            2'd3: b = ip[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/arp_receive_filter_core.sv
// ARP / RARP answer filter.
// item channel (item_valid/item_ready/item): one frame byte per item in wire
//   order, last_byte set on the final byte; func = 1 instead drops the last
//   learned sender MAC and carries no byte.
// result channel (result_valid/result_ready/result): one verdict per frame,
//   with the reject reason and the sender MAC/IP taken from the frame.
// cfg port (cfg_we/cfg_index/cfg_data): register writes, taken at once; the user
//   must write only while no frame is in flight, the block does not enforce it.
// Throughput: one item per cycle while the queue is not full. Per-byte checks
//   run in the front stage as each byte arrives; the verdict is formed in the
//   back stage from the queued frame summary.
// The frame summary is written into the queue when the last byte is accepted,
//   then loaded into the output register, which raises result_valid.
// A stalled result_ready holds the result; the front keeps taking bytes until
//   the 2-entry queue of frame records fills, then item_ready drops.
// Reset: mode = ARP reply, other registers zero, no learned MAC, queue and
//   output empty; item_ready is high as soon as reset is released.
module arp_receive_filter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  arf_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output arf_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [arf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [arf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import arf_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push, queue_full, pop, rec_valid;
    rec_t push_rec, pop_rec;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:              cfg_next.mode = cfg_data[2:0];
                CFG_SRC_FILTER_ENABLE: cfg_next.src_filter_enable = cfg_data[0];
                CFG_SRC_FILTER_MAC:    cfg_next.src_filter_mac = cfg_data[47:0];
                CFG_KEEP_BROADCAST:    cfg_next.keep_broadcast = cfg_data[0];
                CFG_OWN_IP:            cfg_next.own_ip = cfg_data[31:0];
                CFG_OWN_MAC:           cfg_next.own_mac = cfg_data[47:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // byte checks and frame capture
    arf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .push       (push),
        .push_rec   (push_rec),
        .queue_full (queue_full)
    );

    // frame summaries and forget events in order
    arf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (rec_valid),
        .pop_rec   (pop_rec)
    );

    // verdict, learned MAC and output register
    arf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (rec_valid),
        .rec          (pop_rec),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: rtl/arf_front.sv
module arf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  arf_pkg::in_item_t item,
    input  arf_pkg::cfg_t     cfg,
    output logic              push,
    output arf_pkg::rec_t     push_rec,
    input  logic              queue_full
);
    import arf_pkg::*;

    logic [5:0]        count_reg, count_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [15:0]       opcode_reg, opcode_next;
    logic [47:0]       mac_reg, mac_next;
    logic [31:0]       ip_reg, ip_next;

    logic [5:0]        count_upd;
    logic [FLAG_W-1:0] flags_upd;
    logic [15:0]       opcode_upd;
    logic [47:0]       mac_upd;
    logic [31:0]       ip_upd;
    logic              take;
    logic              accept;
    logic [5:0]        pos;
    logic [5:0]        off_src, off_tha, off_tpa;
    logic [7:0]        b;

    assign item_ready = !queue_full;
    assign accept = item_valid && item_ready;
    assign push = accept && (item.func || item.last_byte);

    // per-byte compare against the field at this offset
    always_comb
    begin
        pos = count_reg;
        b = item.frame_byte;
        take = (count_reg < MIN_FRAME_COUNT);
        off_src = pos - POS_SRC_FIRST;
        off_tha = pos - POS_THA_FIRST;
        off_tpa = pos - POS_TPA_FIRST;
        flags_upd = flags_reg;
        opcode_upd = opcode_reg;
        mac_upd = mac_reg;
        ip_upd = ip_reg;
        count_upd = take ? count_reg + 6'd1 : count_reg;
        if (take)
        begin
            if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
            begin
                if (b != mac_byte(cfg.src_filter_mac, off_src[2:0]))
                    flags_upd[FLAG_SRC] = 1'b1;
            end
            else if (pos >= POS_ETYPE_FIRST && pos <= POS_ETYPE_LAST)
            begin
                if (b != (pos[0] ? ETHERTYPE_ARP[7:0] : ETHERTYPE_ARP[15:8]))
                    flags_upd[FLAG_ETYPE] = 1'b1;
            end
            else if (pos >= POS_HW_FIRST && pos <= POS_HW_LAST)
            begin
                if (b != (pos[0] ? HW_ETHER[7:0] : HW_ETHER[15:8]))
                    flags_upd[FLAG_HW] = 1'b1;
            end
            else if (pos >= POS_PROTO_FIRST && pos <= POS_PROTO_LAST)
            begin
                if (b != (pos[0] ? PROTO_IPV4[7:0] : PROTO_IPV4[15:8]))
                    flags_upd[FLAG_PROTO] = 1'b1;
            end
            else if (pos == POS_HLEN)
            begin
                if (b != HLEN_ETHER)
                    flags_upd[FLAG_LEN] = 1'b1;
            end
            else if (pos == POS_PLEN)
            begin
                if (b != PLEN_IPV4)
                    flags_upd[FLAG_LEN] = 1'b1;
            end
            else if (pos >= POS_OP_FIRST && pos <= POS_OP_LAST)
            begin
                opcode_upd = {opcode_reg[7:0], b};
            end
            else if (pos >= POS_SHA_FIRST && pos <= POS_SHA_LAST)
            begin
                mac_upd = {mac_reg[39:0], b};
            end
            else if (pos >= POS_SPA_FIRST && pos <= POS_SPA_LAST)
            begin
                ip_upd = {ip_reg[23:0], b};
            end
            else if (pos >= POS_THA_FIRST && pos <= POS_THA_LAST)
            begin
                if (b != mac_byte(cfg.own_mac, off_tha[2:0]))
                    flags_upd[FLAG_THA] = 1'b1;
            end
            else if (pos >= POS_TPA_FIRST && pos <= POS_TPA_LAST)
            begin
                if (b != ip_byte(cfg.own_ip, off_tpa[1:0]))
                    flags_upd[FLAG_TPA] = 1'b1;
            end
        end
    end

    // record handed to the back part
    always_comb
    begin
        push_rec.is_forget = item.func;
        push_rec.short_frame = (count_upd < MIN_FRAME_COUNT);
        push_rec.flags = flags_upd;
        push_rec.opcode = opcode_upd;
        push_rec.sender_mac = mac_upd;
        push_rec.sender_ip = ip_upd;
        push_rec.mode = cfg.mode;
        push_rec.src_filter_enable = cfg.src_filter_enable;
        push_rec.keep_broadcast = cfg.keep_broadcast;
    end

    // frame state: advance on a byte, clear after the last one
    always_comb
    begin
        count_next = count_reg;
        flags_next = flags_reg;
        opcode_next = opcode_reg;
        mac_next = mac_reg;
        ip_next = ip_reg;
        if (accept && !item.func)
        begin
            if (item.last_byte)
            begin
                count_next = '0;
                flags_next = '0;
                opcode_next = '0;
                mac_next = '0;
                ip_next = '0;
            end
            else
            begin
                count_next = count_upd;
                flags_next = flags_upd;
                opcode_next = opcode_upd;
                mac_next = mac_upd;
                ip_next = ip_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flags_reg <= '0;
            opcode_reg <= '0;
            mac_reg <= '0;
            ip_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            flags_reg <= flags_next;
            opcode_reg <= opcode_next;
            mac_reg <= mac_next;
            ip_reg <= ip_next;
        end
    end

endmodule

FILE: rtl/arf_queue.sv
module arf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  arf_pkg::rec_t push_rec,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output arf_pkg::rec_t pop_rec
);
    import arf_pkg::*;

    rec_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && pop_valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

FILE: rtl/arf_back.sv
module arf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  arf_pkg::rec_t      rec,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output arf_pkg::out_item_t result
);
    import arf_pkg::*;

    logic [47:0] learned_mac_reg, learned_mac_next;
    logic        learned_valid_reg, learned_valid_next;
    logic        result_valid_reg, result_valid_next;
    out_item_t   result_reg, result_next;
    reason_t     reason;
    logic        op_range_ok;
    logic        last_mac_bad;

    assign pop = rec_valid && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // verdict in priority order
    always_comb
    begin
        op_range_ok = (rec.opcode >= OP_ARP_REQUEST) && (rec.opcode <= OP_RARP_REPLY);
        last_mac_bad = !rec.keep_broadcast && learned_valid_reg
                       && (rec.sender_mac != learned_mac_reg);
        reason = REASON_OK;
        if (rec.short_frame)
            reason = REASON_SHORT;
        else if (rec.flags[FLAG_ETYPE])
            reason = REASON_NOT_ARP;
        else if (rec.src_filter_enable && rec.flags[FLAG_SRC])
            reason = REASON_SOURCE;
        else if (!op_range_ok)
            reason = REASON_OPCODE;
        else
        begin
            case (rec.mode)
                MODE_ARP_REPLY:
                begin
                    if (rec.opcode != OP_ARP_REPLY)
                        reason = REASON_OPCODE;
                    else if (last_mac_bad)
                        reason = REASON_LAST_MAC;
                    else if (rec.flags[FLAG_TPA])
                        reason = REASON_TARGET;
                end
                MODE_ARP_REQUEST:
                begin
                    if (rec.opcode != OP_ARP_REQUEST)
                        reason = REASON_OPCODE;
                    else if (rec.flags[FLAG_TPA])
                        reason = REASON_TARGET;
                end
                MODE_RARP_REPLY:
                begin
                    if (rec.opcode != OP_RARP_REPLY)
                        reason = REASON_OPCODE;
                    else if (rec.flags[FLAG_THA])
                        reason = REASON_TARGET;
                end
                MODE_RARP_REQUEST:
                begin
                    if (rec.opcode != OP_RARP_REQUEST)
                        reason = REASON_OPCODE;
                    else if (rec.flags[FLAG_TPA])
                        reason = REASON_TARGET;
                end
                default:
                begin
                    reason = REASON_OK;
                end
            endcase
            if (reason == REASON_OK
                && (rec.flags[FLAG_HW] || rec.flags[FLAG_PROTO] || rec.flags[FLAG_LEN]))
                reason = REASON_FORMAT;
        end
    end

    // output register and learned sender state
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next = result_reg;
        learned_mac_next = learned_mac_reg;
        learned_valid_next = learned_valid_reg;
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;
        if (pop)
        begin
            if (rec.is_forget)
            begin
                learned_valid_next = 1'b0;
            end
            else
            begin
                result_valid_next = 1'b1;
                result_next.accepted = (reason == REASON_OK);
                result_next.reject_reason = reason;
                result_next.sender_mac = rec.short_frame ? 48'd0 : rec.sender_mac;
                result_next.sender_ip = rec.short_frame ? 32'd0 : rec.sender_ip;
                if (reason == REASON_OK)
                begin
                    learned_mac_next = rec.sender_mac;
                    learned_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            learned_valid_reg <= 1'b0;
            learned_mac_reg <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            learned_valid_reg <= learned_valid_next;
            learned_mac_reg <= learned_mac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

FILE: rtl/arf_checker.sv
`include "assert_macros.svh"

module arf_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               result_valid,
    input  logic               result_ready,
    input  arf_pkg::out_item_t result
);
    import arf_pkg::*;

    // a stalled result holds
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

    // accepted flag agrees with the reason code
    `ASSERT_IMPLIES(a_accept_reason, clk, rst_n, result_valid, result.accepted == (result.reject_reason == REASON_OK))

    // short frames carry no sender addresses
    `ASSERT_IMPLIES(a_short_zero, clk, rst_n, result_valid && (result.reject_reason == REASON_SHORT), (result.sender_mac == '0) && (result.sender_ip == '0))

endmodule

bind arp_receive_filter_core arf_checker u_arf_checker (.*);
